FILE: hdl/ratio_to_bounded_fraction_unit_assert.svh
// Assertion macros shared by the bounded-fraction unit.
`ifndef RATIO_TO_BOUNDED_FRACTION_UNIT_ASSERT_SVH
`define RATIO_TO_BOUNDED_FRACTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RTBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RTBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rtbf_pkg.sv
package rtbf_pkg;

  localparam int LIM_W     = 16;
  localparam int NUMER_W   = 32;
  localparam int DENOM_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] TOLERANCE_RST  = 16'd7;
  localparam logic [CFG_W-1:0] TERM_LIMIT_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } rtbf_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_start;
    logic update;
    logic finish;
  } rtbf_cmd_t;

  typedef struct packed {
    logic stop_early;
    logic in_tol;
    logic div_done;
  } rtbf_sts_t;

endpackage

FILE: hdl/rtbf_div.sv
module rtbf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [FRAC_BITS-1:0]   divisor,
  output logic                   done,
  output logic [2*FRAC_BITS:0]   quot
);

  localparam int QB = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QB);
  localparam logic [CW-1:0] LAST = CW'(QB - 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [FRAC_BITS:0] part_r;
  logic [QB-1:0]     quot_r;

  logic [FRAC_BITS:0] shifted;
  logic [FRAC_BITS:0] div_ext;
  logic               ge;
  logic [FRAC_BITS:0] part_nxt;
  logic [QB-1:0]      quot_nxt;

  assign div_ext  = {1'b0, divisor};
  assign shifted  = {part_r[FRAC_BITS-1:0], (cnt_r == '0)};
  assign ge       = (shifted >= div_ext);
  assign part_nxt = ge ? (shifted - div_ext) : shifted;
  assign quot_nxt = {quot_r[QB-2:0], ge};
  assign done     = busy_r && (cnt_r == LAST);
  assign quot     = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part_r <= '0;
    end else if (busy_r) begin
      part_r <= part_nxt;
      quot_r <= quot_nxt;
    end
  end

endmodule

FILE: hdl/rtbf_dp.sv
module rtbf_dp #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [INT_BITS+FRAC_BITS-1:0]           in_ratio,
  input  logic                                    cfg_we,
  input  logic [rtbf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rtbf_pkg::CFG_W-1:0]              cfg_data,
  input  rtbf_pkg::rtbf_cmd_t                     cmd,
  output rtbf_pkg::rtbf_sts_t                     sts,
  output logic                                    out_valid,
  output logic [rtbf_pkg::NUMER_W-1:0]            out_numer_out,
  output logic [rtbf_pkg::DENOM_W-1:0]            out_denom_out,
  output logic                                    out_is_fraction
);

  localparam int RW   = INT_BITS + FRAC_BITS;
  localparam int LW   = rtbf_pkg::LIM_W;
  localparam int NW   = rtbf_pkg::NUMER_W;
  localparam int DW   = rtbf_pkg::DENOM_W;
  localparam int AW   = FRAC_BITS + 1;
  localparam int PW_N = FRAC_BITS + LW + 1;
  localparam int PW   = (INT_BITS > PW_N) ? INT_BITS : PW_N;
  localparam int QW   = PW_N;
  localparam int EW   = RW + LW;
  localparam int TW   = 2 * LW;
  localparam int RMW  = FRAC_BITS + LW;

  logic [LW-1:0]        tol_r;
  logic [LW-1:0]        lim_r;
  logic [RW-1:0]        ratio_r;
  logic [PW-1:0]        p_r;
  logic [QW-1:0]        q_r;
  logic [LW-1:0]        pp_r;
  logic [LW-1:0]        qp_r;
  logic [FRAC_BITS-1:0] rem_r;
  logic [EW-1:0]        prod_r;
  logic [TW-1:0]        tolq_r;
  logic                 out_valid_r;
  logic [NW-1:0]        numer_r;
  logic [DW-1:0]        denom_r;
  logic                 frac_r;

  logic                 div_done;
  logic [2*FRAC_BITS:0] recip;
  logic [AW-1:0]        a_term;
  logic [PW-1:0]        p_nxt;
  logic [QW-1:0]        q_nxt;
  logic                 p_fits;
  logic                 q_fits;
  logic [EW-1:0]        lhs;
  logic [EW-1:0]        err;

  rtbf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .divisor(rem_r),
    .done   (div_done),
    .quot   (recip)
  );

  assign a_term = recip[2*FRAC_BITS:FRAC_BITS];
  assign p_nxt  = PW'(PW_N'(a_term) * PW_N'(p_r[LW-1:0]) + PW_N'(pp_r));
  assign q_nxt  = QW'(PW_N'(a_term) * PW_N'(q_r[LW-1:0]) + PW_N'(qp_r));

  assign p_fits = (p_r < PW'(lim_r));
  assign q_fits = (q_r < QW'(lim_r));

  assign lhs = EW'({p_r[LW-1:0], {FRAC_BITS{1'b0}}});
  assign err = (lhs >= prod_r) ? (lhs - prod_r) : (prod_r - lhs);

  always_comb begin
    sts            = '0;
    sts.stop_early = (rem_r == '0) || (RMW'(rem_r) < RMW'(tol_r)) || !p_fits || !q_fits;
    sts.in_tol     = (err <= EW'(tolq_r));
    sts.div_done   = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= rtbf_pkg::TOLERANCE_RST;
      lim_r <= rtbf_pkg::TERM_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rtbf_pkg::CFG_TOLERANCE:  tol_r <= cfg_data;
        rtbf_pkg::CFG_TERM_LIMIT: lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ratio_r <= in_ratio;
      p_r     <= PW'(in_ratio[RW-1:FRAC_BITS]);
      q_r     <= QW'(1);
      pp_r    <= LW'(1);
      qp_r    <= '0;
      rem_r   <= in_ratio[FRAC_BITS-1:0];
    end else if (cmd.update) begin
      p_r   <= p_nxt;
      q_r   <= q_nxt;
      pp_r  <= p_r[LW-1:0];
      qp_r  <= q_r[LW-1:0];
      rem_r <= recip[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      prod_r <= EW'(ratio_r) * EW'(q_r[LW-1:0]);
      tolq_r <= TW'(tol_r) * TW'(q_r[LW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (p_fits && q_fits) begin
        numer_r <= NW'(p_r[LW-1:0]);
        denom_r <= DW'(q_r[LW-1:0]);
        frac_r  <= 1'b1;
      end else begin
        numer_r <= NW'(ratio_r);
        denom_r <= DW'(1);
        frac_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numer_out   = numer_r;
  assign out_denom_out   = denom_r;
  assign out_is_fraction = frac_r;

endmodule

FILE: hdl/rtbf_ctrl.sv
module rtbf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rtbf_pkg::rtbf_sts_t sts,
  output logic                busy,
  output rtbf_pkg::rtbf_cmd_t cmd
);

  rtbf_pkg::rtbf_state_t state_r;
  rtbf_pkg::rtbf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtbf_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = rtbf_pkg::ST_CHECK;
        end
      end
      rtbf_pkg::ST_CHECK: begin
        state_nxt = sts.stop_early ? rtbf_pkg::ST_FINISH : rtbf_pkg::ST_TEST;
      end
      rtbf_pkg::ST_TEST: begin
        state_nxt = sts.in_tol ? rtbf_pkg::ST_FINISH : rtbf_pkg::ST_DIVIDE;
      end
      rtbf_pkg::ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = rtbf_pkg::ST_UPDATE;
        end
      end
      rtbf_pkg::ST_UPDATE: state_nxt = rtbf_pkg::ST_CHECK;
      rtbf_pkg::ST_FINISH: state_nxt = rtbf_pkg::ST_IDLE;
      default:             state_nxt = rtbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      rtbf_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      rtbf_pkg::ST_CHECK:  cmd.check = 1'b1;
      rtbf_pkg::ST_TEST:   cmd.div_start = !sts.in_tol;
      rtbf_pkg::ST_DIVIDE: ;
      rtbf_pkg::ST_UPDATE: cmd.update = 1'b1;
      rtbf_pkg::ST_FINISH: cmd.finish = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule

FILE: hdl/ratio_to_bounded_fraction_unit.sv
// Approximates an unsigned fixed-point ratio by a continued-fraction
// convergent p/q. Pulse start while busy is low to hand over one request;
// exactly one result follows, shown for a single cycle with out_valid high,
// and the receiver cannot stall it, so capture it in that cycle. A request
// keeps busy high for (2*FRAC_BITS + 4) * T + 2 cycles, or + 3 when the
// tolerance test ends it, where T is the number of terms taken (36 cycles a
// term with the default 16 fraction bits, and at most 24 terms, since q grows
// at least as fast as the Fibonacci numbers and must stay below the 16-bit
// term_limit); the term cost is set by the bit-serial reciprocal divider,
// which produces one quotient bit a cycle. The result strobe comes in the
// first cycle that busy is low again. Write cfg_* registers only while idle.
`include "ratio_to_bounded_fraction_unit_assert.svh"

module ratio_to_bounded_fraction_unit #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [INT_BITS+FRAC_BITS-1:0]      in_ratio,
  output logic                               out_valid,
  output logic [rtbf_pkg::NUMER_W-1:0]       out_numer_out,
  output logic [rtbf_pkg::DENOM_W-1:0]       out_denom_out,
  output logic                               out_is_fraction,
  input  logic                               cfg_we,
  input  logic [rtbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtbf_pkg::CFG_W-1:0]         cfg_data
);

  rtbf_pkg::rtbf_cmd_t ctrl_cmd;
  rtbf_pkg::rtbf_sts_t ctrl_sts;

  rtbf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (ctrl_sts),
    .busy (busy),
    .cmd  (ctrl_cmd)
  );

  rtbf_dp #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ratio       (in_ratio),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (ctrl_cmd),
    .sts            (ctrl_sts),
    .out_valid      (out_valid),
    .out_numer_out  (out_numer_out),
    .out_denom_out  (out_denom_out),
    .out_is_fraction(out_is_fraction)
  );

  `RTBF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `RTBF_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `RTBF_ASSERT_NOW(a_strobe_src, out_valid, $past(ctrl_cmd.finish), "result without finish step")
  `RTBF_ASSERT_NOW(a_fallback_den, out_valid && !out_is_fraction, out_denom_out == 16'd1, "fallback denominator not one")

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtbf_pkg::*;

  localparam int FRAC = 16;
  localparam int RATIO_W = 32;

  typedef struct packed {
    logic [NUMER_W-1:0] numer;
    logic [DENOM_W-1:0] denom;
    logic               is_frac;
  } fraction_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [RATIO_W-1:0]   in_ratio = '0;
  logic                 out_valid;
  logic [NUMER_W-1:0]   out_numer_out;
  logic [DENOM_W-1:0]   out_denom_out;
  logic                 out_is_fraction;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [CFG_W-1:0]   tol_cfg = TOLERANCE_RST;
  logic [CFG_W-1:0]   lim_cfg = TERM_LIMIT_RST;
  logic [RATIO_W-1:0] ratio_backlog[$];
  fraction_t          fraction_q[$];
  int                 mismatches = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;

  ratio_to_bounded_fraction_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_ratio       (in_ratio),
    .out_valid      (out_valid),
    .out_numer_out  (out_numer_out),
    .out_denom_out  (out_denom_out),
    .out_is_fraction(out_is_fraction),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("FAIL ratio_to_bounded_fraction_unit");
    $finish;
  end

  function automatic fraction_t approx_fraction(logic [RATIO_W-1:0] ratio);
    longint unsigned r, p, q, p_prev, q_prev, rem, recip, a, p_next, q_next;
    longint unsigned lhs, rhs, err, tol, lim;
    fraction_t f;
    r = 64'(ratio);
    tol = 64'(tol_cfg);
    lim = 64'(lim_cfg);
    p_prev = 1;
    q_prev = 0;
    p = r >> FRAC;
    q = 1;
    rem = r & 64'hFFFF;
    forever begin
      if (rem == 0 || rem < tol || p >= lim || q >= lim) break;
      lhs = p << FRAC;
      rhs = r * q;
      err = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
      if (err <= tol * q) break;
      recip = (64'd1 << (2 * FRAC)) / rem;
      a = recip >> FRAC;
      p_next = a * p + p_prev;
      q_next = a * q + q_prev;
      p_prev = p;
      q_prev = q;
      p = p_next;
      q = q_next;
      rem = recip & 64'hFFFF;
    end
    if (p < lim && q < lim) begin
      f.numer = p[NUMER_W-1:0];
      f.denom = q[DENOM_W-1:0];
      f.is_frac = 1'b1;
    end else begin
      f.numer = ratio;
      f.denom = DENOM_W'(1);
      f.is_frac = 1'b0;
    end
    return f;
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    logic [15:0] ip, fp;
    logic [31:0] scaled;
    int unsigned mode, qd;
    mode = $urandom_range(0, 7);
    fp = 16'($urandom);
    ip = 16'($urandom_range(0, 255));
    case (mode)
      0, 1: return $urandom;
      2, 3: ip = 16'($urandom_range(0, 3));
      4: ip = (lim_cfg >= 2) ? lim_cfg - 16'($urandom_range(0, 2))
                             : 16'($urandom_range(0, 1));
      5: begin
        qd = $urandom_range(1, 60);
        scaled = {16'($urandom_range(0, 3000)), 16'h0};
        return scaled / qd + $urandom_range(0, 1);
      end
      6: begin
        ip = 16'($urandom_range(0, 20));
        fp = 16'($urandom_range(0, 16));
      end
      default: ;
    endcase
    return {ip, fp};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic settle();
    while (ratio_backlog.size() != 0 || start || fraction_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [CFG_W-1:0] tol, logic [CFG_W-1:0] lim);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= CFG_TERM_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_cfg = tol;
    lim_cfg = lim;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] tol, logic [CFG_W-1:0] lim, int n);
    set_limits(tol, lim);
    repeat (n) ratio_backlog.push_back(pick_ratio());
    settle();
  endtask

  // driver: bursts of back-to-back requests, random gaps while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) fraction_q.push_back(approx_fraction(in_ratio));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          if (!busy) gap_left--;
          start <= 1'b0;
        end else if (ratio_backlog.size() != 0) begin
          start <= 1'b1;
          in_ratio <= ratio_backlog.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    fraction_t want;
    if (rst_n && out_valid) begin
      if (fraction_q.size() == 0) begin
        report_mismatch("unexpected result", out_numer_out, 32'h0);
      end else begin
        want = fraction_q.pop_front();
        if (out_numer_out !== want.numer)
          report_mismatch("numer_out", out_numer_out, want.numer);
        if (out_denom_out !== want.denom)
          report_mismatch("denom_out", 32'(out_denom_out), 32'(want.denom));
        if (out_is_fraction !== want.is_frac)
          report_mismatch("is_fraction", 32'(out_is_fraction), 32'(want.is_frac));
      end
    end
  end

  initial begin : sequencer
    int k;
    logic [CFG_W-1:0] tol, lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    ratio_backlog = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000,
                      32'h0000_0001, 32'h0000_FFFF, 32'h0003_243F, 32'h03E7_0000,
                      32'h03E8_0000, 32'h03E7_8000, 32'hFFFF_0000, 32'h0001_5555,
                      32'h0000_0007, 32'h0000_0006, 32'h0001_9E37, 32'h0001_6A09,
                      32'h0002_0000, 32'h0000_4000};
    repeat (150) ratio_backlog.push_back(pick_ratio());
    settle();

    set_limits(16'd0, 16'hFFFF);
    ratio_backlog = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_243F};
    repeat (120) ratio_backlog.push_back(pick_ratio());
    settle();

    run_phase(16'hFFFF, 16'd1, 60);
    run_phase(16'hFFFF, 16'hFFFF, 60);
    run_phase(16'd0, 16'd2, 60);

    for (k = 0; k < 5; k++) begin
      tol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      lim = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1, 2000));
      run_phase(tol, lim, 100);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && fraction_q.size() == 0) begin
      $display("PASS ratio_to_bounded_fraction_unit");
    end else begin
      $display("FAIL ratio_to_bounded_fraction_unit");
    end
    $finish;
  end

endmodule

FILE: ratio_to_bounded_fraction_unit.f
+incdir+hdl
hdl/rtbf_pkg.sv
hdl/rtbf_div.sv
hdl/rtbf_dp.sv
hdl/rtbf_ctrl.sv
hdl/ratio_to_bounded_fraction_unit.sv
dv/tb.sv
